[rtl/core/bsc_pkg.sv]
package bsc_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SRC_OFS    = 2'd0,
        CFG_DST_OFS    = 2'd1,
        CFG_BIT_COUNT  = 2'd2,
        CFG_HEAD_BYTE  = 2'd3
    } t_cfg_idx;

    // One destination item.
    typedef struct packed {
        logic [7:0] dst_byte;
        logic       last_out;
    } t_result;

    // Output queue geometry.
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoPtrW  = 2;
    localparam int unsigned FifoCntW  = 3;

    // Bit positions within a byte, MSB first.
    localparam int unsigned ByteBits = 8;
    localparam logic [2:0]  OfsMask  = 3'h7;

endpackage

[rtl/core/bsc_in_if.sv]
interface bsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink   (input valid, input src_byte, output ready);
endinterface

[rtl/core/bsc_out_if.sv]
interface bsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] dst_byte;
    logic       last_out;

    modport source (output valid, output dst_byte, output last_out, input ready);
    modport sink   (input valid, input dst_byte, input last_out, output ready);
endinterface

[rtl/core/bit_aligned_stream_copy.sv]
// Bit-aligned stream copy. Moves bit_count bits from an MSB-first source byte
// stream, whose first bit sits src_bit_offset bits below bit 7 of the first
// source byte, to an MSB-first destination stream starting dst_bit_offset bits
// into the first destination byte; that byte keeps the top bits of
// dst_head_byte. Bits after the copy are zero and last_out marks the final
// destination byte. A copy starts on the first source item after reset or
// after the previous copy ends, and the registers are sampled at that point.
// One source item is accepted per clock; its destination items are computed
// in the same cycle and placed in a four-entry output queue. Most items give
// one destination item, so the rate is one item per cycle; the last item of a
// copy may give two. The input is held off only while the output queue holds
// more than two items.
module bit_aligned_stream_copy #(
    parameter int unsigned LEN_WIDTH = 21
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_idx,
    input  logic [((LEN_WIDTH > 8) ? LEN_WIDTH : 8)-1:0] i_cfg_wdata,
    bsc_in_if.sink                                 i_src,
    bsc_out_if.source                              o_dst
);

    logic [2:0]           r_src_ofs;
    logic [2:0]           r_dst_ofs;
    logic [LEN_WIDTH-1:0] r_bit_count;
    logic [7:0]           r_head_byte;

    logic                 fire;
    logic                 room;
    logic [1:0]           push_cnt;
    bsc_pkg::t_result     res0;
    bsc_pkg::t_result     res1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_ofs   <= '0;
            r_dst_ofs   <= '0;
            r_bit_count <= LEN_WIDTH'(8);
            r_head_byte <= '0;
        end else if (i_cfg_we) begin
            unique case (bsc_pkg::t_cfg_idx'(i_cfg_idx))
                bsc_pkg::CFG_SRC_OFS:   r_src_ofs   <= i_cfg_wdata[2:0];
                bsc_pkg::CFG_DST_OFS:   r_dst_ofs   <= i_cfg_wdata[2:0];
                bsc_pkg::CFG_BIT_COUNT: r_bit_count <= i_cfg_wdata[LEN_WIDTH-1:0];
                bsc_pkg::CFG_HEAD_BYTE: r_head_byte <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign i_src.ready = room;
    assign fire        = i_src.valid && room;

    bsc_realign #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_realign (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_src_byte  (i_src.src_byte),
        .i_src_ofs   (r_src_ofs),
        .i_dst_ofs   (r_dst_ofs),
        .i_bit_count (r_bit_count),
        .i_head_byte (r_head_byte),
        .o_push_cnt  (push_cnt),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    bsc_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_room     (room),
        .o_dst      (o_dst)
    );

endmodule

[rtl/core/bsc_realign.sv]
module bsc_realign #(
    parameter int unsigned LEN_WIDTH = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_src_byte,
    input  logic [2:0]           i_src_ofs,
    input  logic [2:0]           i_dst_ofs,
    input  logic [LEN_WIDTH-1:0] i_bit_count,
    input  logic [7:0]           i_head_byte,
    output logic [1:0]           o_push_cnt,
    output bsc_pkg::t_result     o_res0,
    output bsc_pkg::t_result     o_res1
);

    // Copy state carried from one item to the next.
    logic                 r_first;
    logic [6:0]           r_pend_bits;
    logic [2:0]           r_pend_cnt;
    logic [LEN_WIDTH-1:0] r_bits_rem;

    logic [6:0]           acc;
    logic [3:0]           cnt;
    logic [LEN_WIDTH-1:0] rem;
    logic [7:0]           val;
    logic [3:0]           avail;
    logic [3:0]           take;
    logic [14:0]          acc_sh;
    logic [3:0]           cnt_sum;
    logic [2:0]           cnt_left;
    logic [LEN_WIDTH-1:0] rem_n;
    logic [6:0]           acc_left;
    logic                 full;
    logic                 done;
    logic                 tail;
    logic [7:0]           byte_full;
    logic [7:0]           byte_tail;

    // Select the starting point: a fresh copy loads the configuration.
    always_comb begin
        if (r_first) begin
            acc   = (i_dst_ofs != 3'd0)
                  ? 7'(i_head_byte >> (4'(bsc_pkg::ByteBits) - {1'b0, i_dst_ofs})) : 7'd0;
            cnt   = {1'b0, i_dst_ofs & bsc_pkg::OfsMask};
            rem   = i_bit_count;
            val   = i_src_byte & (8'hFF >> i_src_ofs);
            avail = 4'(bsc_pkg::ByteBits) - {1'b0, i_src_ofs};
        end else begin
            acc   = r_pend_bits;
            cnt   = {1'b0, r_pend_cnt};
            rem   = r_bits_rem;
            val   = i_src_byte;
            avail = 4'(bsc_pkg::ByteBits);
        end
    end

    // Merge the taken source bits below the pending bits.
    always_comb begin
        take      = (LEN_WIDTH'(avail) < rem) ? avail : rem[3:0];
        acc_sh    = (15'(acc) << take) | 15'(val >> (avail - take));
        cnt_sum   = cnt + take;
        rem_n     = rem - LEN_WIDTH'(take);
        full      = cnt_sum[3];
        cnt_left  = cnt_sum[2:0];
        done      = (rem_n == '0);
        tail      = done && (cnt_left != 3'd0);
        byte_full = 8'(acc_sh >> cnt_left);
        acc_left  = 7'(acc_sh & ((15'd1 << cnt_left) - 15'd1));
        byte_tail = 8'(15'(acc_left) << (4'(bsc_pkg::ByteBits) - {1'b0, cnt_left}));
    end

    // Pack the produced items so that the first one is always in slot zero.
    always_comb begin
        o_res0.dst_byte = byte_full;
        o_res0.last_out = done && (cnt_left == 3'd0);
        o_res1.dst_byte = byte_tail;
        o_res1.last_out = 1'b1;
        o_push_cnt      = 2'd0;
        if (i_fire) begin
            if (full && tail) begin
                o_push_cnt = 2'd2;
            end else if (full) begin
                o_push_cnt = 2'd1;
            end else if (tail) begin
                o_push_cnt = 2'd1;
                o_res0     = o_res1;
            end
        end
    end

    // State update on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b1;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_bits_rem  <= '0;
        end else if (i_fire) begin
            r_first     <= done;
            r_pend_bits <= done ? 7'd0 : acc_left;
            r_pend_cnt  <= done ? 3'd0 : cnt_left;
            r_bits_rem  <= rem_n;
        end
    end

endmodule

[rtl/core/bsc_out_fifo.sv]
module bsc_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_cnt,
    input  bsc_pkg::t_result      i_res0,
    input  bsc_pkg::t_result      i_res1,
    output logic                  o_room,
    bsc_out_if.source             o_dst
);

    bsc_pkg::t_result                   r_mem [bsc_pkg::FifoDepth];
    logic [bsc_pkg::FifoPtrW-1:0]       r_wp;
    logic [bsc_pkg::FifoPtrW-1:0]       r_rp;
    logic [bsc_pkg::FifoCntW-1:0]       r_cnt;
    logic [bsc_pkg::FifoPtrW-1:0]       wp_next;
    logic                               pop;

    assign pop     = o_dst.valid && o_dst.ready;
    assign wp_next = r_wp + 1'b1;

    // Room for two more items means a new input item can always be taken.
    assign o_room  = (r_cnt <= bsc_pkg::FifoCntW'(bsc_pkg::FifoDepth - 2));

    assign o_dst.valid    = (r_cnt != '0);
    assign o_dst.dst_byte = r_mem[r_rp].dst_byte;
    assign o_dst.last_out = r_mem[r_rp].last_out;

    // Item storage, written one or two entries at a time.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp_next] <= i_res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + bsc_pkg::FifoPtrW'(i_push_cnt);
            r_rp  <= r_rp + bsc_pkg::FifoPtrW'(pop);
            r_cnt <= r_cnt + bsc_pkg::FifoCntW'(i_push_cnt) - bsc_pkg::FifoCntW'(pop);
        end
    end

endmodule
